/* rtl/tmp_pkg.sv */
package tmp_pkg;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_ABS  = 2'd1,
		OP_REL  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_FWD_ACC = 3'd1,
		PH_FWD_DEC = 3'd2,
		PH_REV_ACC = 3'd3,
		PH_REV_DEC = 3'd4
	} phase_t;

	localparam int unsigned VEL_BITS  = 17;
	localparam int unsigned STEP_BITS = 14;

	// divide by ten as multiply by ceil(2^20/10), exact for 18-bit dividends
	localparam int unsigned DIV10_SHIFT = 20;
	localparam logic [VEL_BITS-1:0] DIV10_MUL = 17'd104858;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] target;
		logic [15:0]        peak_velocity;
		logic [15:0]        acceleration;
	} tmp_item_t;

	typedef struct packed {
		phase_t              phase;
		logic [VEL_BITS-1:0] vel;
		logic [15:0]         vlim;
		logic [15:0]         acc;
	} prof_ctl_t;

endpackage

/* rtl/tmp_next.sv */
module tmp_next import tmp_pkg::*; #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  tmp_item_t                        item,
	input  logic signed [POSITION_BITS-1:0]  pos,
	input  logic signed [POSITION_BITS-1:0]  mark,
	input  logic signed [POSITION_BITS-1:0]  goal,
	input  prof_ctl_t                        ctl,
	output logic signed [POSITION_BITS-1:0]  pos_nxt,
	output logic signed [POSITION_BITS-1:0]  mark_nxt,
	output logic signed [POSITION_BITS-1:0]  goal_nxt,
	output prof_ctl_t                        ctl_nxt,
	output logic [31:0]                      cmd_pos,
	output logic                             done
);

	localparam int unsigned EW = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;
	localparam logic signed [EW-1:0] POS_MAX =
		{{(EW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
	localparam logic signed [EW-1:0] POS_MIN = ~POS_MAX;
	localparam int unsigned PROD_BITS = 2 * VEL_BITS;

	function automatic logic signed [EW-1:0] sat_pos(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] r;
		r = v;
		if (v > POS_MAX) r = POS_MAX;
		else if (v < POS_MIN) r = POS_MIN;
		return r;
	endfunction

	logic signed [EW-1:0] pos_e, mark_e, goal_e, tgt_e;
	logic signed [EW-1:0] goal_raw, goal_new;
	logic signed [EW-1:0] diff, half, mid;
	logic signed [EW-1:0] step_e, pos_mov, mark_eff, mirror;
	logic signed [EW-1:0] pos_n, mark_n, goal_n;
	logic                 start, fwd, accel_ph, past_mid, ramping, ramp_over;
	logic                 beyond_mark, beyond_goal, hold;
	logic [VEL_BITS:0]    vel_sum, acc3;
	logic [VEL_BITS-1:0]  vel_ramp, step_vel, vel_slow, acc2;
	logic [PROD_BITS-1:0] prod;
	logic [STEP_BITS-1:0] quot, step;

	assign pos_e  = {{(EW-POSITION_BITS){pos[POSITION_BITS-1]}}, pos};
	assign mark_e = {{(EW-POSITION_BITS){mark[POSITION_BITS-1]}}, mark};
	assign goal_e = {{(EW-POSITION_BITS){goal[POSITION_BITS-1]}}, goal};
	assign tgt_e  = {{(EW-32){item.target[31]}}, item.target};

	assign start    = (item.op == OP_ABS) || (item.op == OP_REL);
	assign goal_raw = (item.op == OP_ABS) ? tgt_e : pos_e + tgt_e;
	assign goal_new = sat_pos(goal_raw);

	assign fwd      = (ctl.phase == PH_FWD_ACC) || (ctl.phase == PH_FWD_DEC);
	assign accel_ph = (ctl.phase == PH_FWD_ACC) || (ctl.phase == PH_REV_ACC);
	assign hold     = (ctl.phase == PH_FWD_ACC) && (ctl.vlim == 16'd0);

	// midpoint with the halving rounded toward zero
	assign diff     = goal_e - mark_e;
	assign half     = (diff + $signed({{(EW-1){1'b0}}, diff[EW-1]})) >>> 1;
	assign mid      = mark_e + half;
	assign past_mid = fwd ? (pos_e > mid) : (pos_e < mid);
	assign ramping  = accel_ph && !past_mid;

	assign vel_sum   = {1'b0, ctl.vel} + {{(VEL_BITS-15){1'b0}}, ctl.acc};
	assign ramp_over = vel_sum > {{(VEL_BITS-15){1'b0}}, ctl.vlim};
	assign vel_ramp  = ramp_over ? {{(VEL_BITS-16){1'b0}}, ctl.vlim} : vel_sum[VEL_BITS-1:0];

	assign acc2     = {ctl.acc, 1'b0};
	assign acc3     = {1'b0, acc2} + {{(VEL_BITS-15){1'b0}}, ctl.acc};
	assign vel_slow = ({1'b0, ctl.vel} < acc3) ? acc2
		: ctl.vel - {{(VEL_BITS-16){1'b0}}, ctl.acc};

	// step = max(velocity / 10, 1)
	assign step_vel = ramping ? vel_ramp : ctl.vel;
	assign prod     = step_vel * DIV10_MUL;
	assign quot     = prod[DIV10_SHIFT +: STEP_BITS];
	assign step     = (quot == '0) ? {{(STEP_BITS-1){1'b0}}, 1'b1} : quot;
	assign step_e   = {{(EW-STEP_BITS){1'b0}}, step};

	assign pos_mov     = sat_pos(fwd ? pos_e + step_e : pos_e - step_e);
	assign mark_eff    = accel_ph ? pos_e : mark_e;
	assign beyond_mark = fwd ? (pos_mov > mark_eff) : (pos_mov < mark_eff);
	assign beyond_goal = fwd ? (pos_mov > goal_e) : (pos_mov < goal_e);
	assign mirror      = sat_pos(goal_e - (pos_e - mark_e));

	always_comb begin
		pos_n   = pos_e;
		mark_n  = mark_e;
		goal_n  = goal_e;
		ctl_nxt = ctl;
		done    = 1'b0;
		if (start) begin
			goal_n       = goal_new;
			mark_n       = pos_e;
			ctl_nxt.vlim = item.peak_velocity;
			ctl_nxt.acc  = item.acceleration;
			ctl_nxt.vel  = '0;
			ctl_nxt.phase = (goal_new > pos_e) ? PH_FWD_ACC : PH_REV_ACC;
		end else begin
			unique case (ctl.phase)
				PH_FWD_ACC, PH_REV_ACC, PH_FWD_DEC, PH_REV_DEC: begin
					if (!hold) begin
						pos_n = pos_mov;
						if (ramping) begin
							ctl_nxt.vel = vel_ramp;
							if (ramp_over) begin
								mark_n = mirror;
								ctl_nxt.phase = fwd ? PH_FWD_DEC : PH_REV_DEC;
							end
						end else begin
							mark_n = mark_eff;
							ctl_nxt.phase = fwd ? PH_FWD_DEC : PH_REV_DEC;
							if (beyond_mark) ctl_nxt.vel = vel_slow;
							if (beyond_goal) begin
								pos_n = goal_e;
								ctl_nxt.phase = PH_IDLE;
								done = 1'b1;
							end
						end
					end
				end
				default: ctl_nxt.phase = PH_IDLE;
			endcase
		end
	end

	assign pos_nxt  = pos_n[POSITION_BITS-1:0];
	assign mark_nxt = mark_n[POSITION_BITS-1:0];
	assign goal_nxt = goal_n[POSITION_BITS-1:0];
	assign cmd_pos  = pos_n[31:0];

endmodule

/* rtl/trapezoid_move_profiler_core.sv */
// Single-axis trapezoidal move profiler.
// Input channel (in_valid / in_stall): one word per command; operation 0 is a
// tick of the control loop, 1 starts a move to an absolute target, 2 starts a
// move by a relative offset, each carrying its peak velocity and acceleration.
// Output channel (out_valid / out_stall): exactly one word per input word,
// in order, with the commanded position after that word, moving, done_res
// (set on the tick that lands on the target) and the profile phase.
// Each accepted word is held in the input register, then goes through the profile
// update, whose result is written into the profile state and into the output
// register in the same cycle. The update is a single registered step, so one
// word is taken every cycle while the output side keeps up; the next word
// sees the state left by the previous one without any bubble.
// When the receiver stalls, the result holds in the output register, the
// word in the input register waits and in_stall rises; nothing is dropped.
// Reset clears the position, target, velocity and profile to idle at zero,
// and empties both registers.
module trapezoid_move_profiler_core import tmp_pkg::*; #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] target,
	input  logic [15:0]        peak_velocity,
	input  logic [15:0]        acceleration,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] command_position,
	output logic               moving,
	output logic               done_res,
	output logic [2:0]         phase
);

	tmp_item_t item_s1;
	logic      valid_s1;
	logic      advance, in_accept;

	logic signed [POSITION_BITS-1:0] pos_q, mark_q, goal_q;
	logic signed [POSITION_BITS-1:0] pos_nxt, mark_nxt, goal_nxt;
	prof_ctl_t ctl_q, ctl_nxt;
	logic [31:0] cmd_pos;
	logic        done;

	logic               out_valid_q, moving_q, done_q;
	logic signed [31:0] cmd_q;
	phase_t             phase_q;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.op            <= operation;
			item_s1.target        <= target;
			item_s1.peak_velocity <= peak_velocity;
			item_s1.acceleration  <= acceleration;
		end
	end

	tmp_next #(
		.POSITION_BITS(POSITION_BITS)
	) u_next (
		.item     (item_s1),
		.pos      (pos_q),
		.mark     (mark_q),
		.goal     (goal_q),
		.ctl      (ctl_q),
		.pos_nxt  (pos_nxt),
		.mark_nxt (mark_nxt),
		.goal_nxt (goal_nxt),
		.ctl_nxt  (ctl_nxt),
		.cmd_pos  (cmd_pos),
		.done     (done)
	);

	// profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mark_q <= '0;
			goal_q <= '0;
			ctl_q  <= '{phase: PH_IDLE, vel: '0, vlim: '0, acc: '0};
		end else if (advance) begin
			pos_q  <= pos_nxt;
			mark_q <= mark_nxt;
			goal_q <= goal_nxt;
			ctl_q  <= ctl_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q    <= cmd_pos;
			moving_q <= (ctl_nxt.phase != PH_IDLE);
			done_q   <= done;
			phase_q  <= ctl_nxt.phase;
		end
	end

	assign out_valid        = out_valid_q;
	assign command_position = cmd_q;
	assign moving           = moving_q;
	assign done_res         = done_q;
	assign phase            = phase_q;

	a_done_ends_profile: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !moving_q && (phase_q == PH_IDLE))
		else $error("done word still shows an active profile");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_advance_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word produced no result");

	a_start_enters_accel: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ((item_s1.op == OP_ABS) || (item_s1.op == OP_REL))
		|=> (ctl_q.phase == PH_FWD_ACC) || (ctl_q.phase == PH_REV_ACC))
		else $error("move start did not enter an accelerating phase");

	a_idle_no_motion: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (ctl_q.phase == PH_IDLE) && (item_s1.op != OP_ABS)
		&& (item_s1.op != OP_REL) |=> $stable(pos_q))
		else $error("position moved while idle");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb import tmp_pkg::*;;

	localparam int POS_BITS = 32;
	localparam int N_DIR = 25;
	localparam int N_RANDOM = 1350;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic signed [31:0] pos;
		bit                 moving;
		bit                 done;
		phase_t             ph;
	} profile_out_t;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] tgt;
		logic [15:0]        vel;
		logic [15:0]        acc;
		bit                 typed;
		logic signed [31:0] want_pos;
		bit                 want_moving;
		bit                 want_done;
		phase_t             want_ph;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic signed [31:0] target;
	logic [15:0]        peak_velocity;
	logic [15:0]        acceleration;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] command_position;
	logic               moving;
	logic               done_res;
	logic [2:0]         phase;

	// predicted profile state
	longint cmd_pos, brake_mark, goal_pos, cur_vel, vel_cap, accel_inc;
	phase_t prof_phase;
	bit     landed;

	profile_out_t predicted_profile[$];
	int           mismatch_count;
	int           burst_left;
	int           counted_words;
	int           stall_left;
	int           stall_mode;
	int           mode_age;

	trapezoid_move_profiler_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.target           (target),
		.peak_velocity    (peak_velocity),
		.acceleration     (acceleration),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.command_position (command_position),
		.moving           (moving),
		.done_res         (done_res),
		.phase            (phase)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb failed");
		$finish;
	end

	function automatic longint clamp_pos(longint v);
		longint top;
		top = (longint'(1) << (POS_BITS - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic longint step_size(longint v);
		longint t;
		t = v / 10;
		if (t < 1)
			t = 1;
		return t;
	endfunction

	function automatic void brake();
		cur_vel = cur_vel - accel_inc;
		if (cur_vel < accel_inc * 2)
			cur_vel = accel_inc * 2;
	endfunction

	function automatic void glide_fwd();
		cmd_pos = clamp_pos(cmd_pos + step_size(cur_vel));
		if (cmd_pos > brake_mark)
			brake();
		if (cmd_pos > goal_pos) begin
			cmd_pos = goal_pos;
			prof_phase = PH_IDLE;
			landed = 1'b1;
		end
	endfunction

	function automatic void glide_rev();
		cmd_pos = clamp_pos(cmd_pos - step_size(cur_vel));
		if (cmd_pos < brake_mark)
			brake();
		if (cmd_pos < goal_pos) begin
			cmd_pos = goal_pos;
			prof_phase = PH_IDLE;
			landed = 1'b1;
		end
	endfunction

	// reaching the peak mirrors the distance covered so far to get the brake point
	function automatic void speed_up();
		cur_vel = cur_vel + accel_inc;
		if (cur_vel > vel_cap) begin
			cur_vel = vel_cap;
			brake_mark = clamp_pos(goal_pos - (cmd_pos - brake_mark));
			prof_phase = (prof_phase == PH_FWD_ACC) ? PH_FWD_DEC : PH_REV_DEC;
		end
	endfunction

	function automatic profile_out_t step_profile(logic [1:0] op, logic signed [31:0] tgt,
			logic [15:0] vel, logic [15:0] acc);
		profile_out_t r;
		longint mid;
		landed = 1'b0;
		if (op == OP_ABS || op == OP_REL) begin
			goal_pos = clamp_pos((op == OP_ABS) ? longint'(tgt) : cmd_pos + longint'(tgt));
			vel_cap = longint'(vel);
			accel_inc = longint'(acc);
			cur_vel = 0;
			brake_mark = cmd_pos;
			prof_phase = (goal_pos > cmd_pos) ? PH_FWD_ACC : PH_REV_ACC;
		end else begin
			mid = brake_mark + (goal_pos - brake_mark) / 2;
			case (prof_phase)
				PH_FWD_ACC: begin
					// zero peak velocity holds the forward ramp in place
					if (vel_cap != 0) begin
						if (cmd_pos > mid) begin
							brake_mark = cmd_pos;
							prof_phase = PH_FWD_DEC;
							glide_fwd();
						end else begin
							speed_up();
							cmd_pos = clamp_pos(cmd_pos + step_size(cur_vel));
						end
					end
				end
				PH_FWD_DEC: glide_fwd();
				PH_REV_ACC: begin
					if (cmd_pos < mid) begin
						brake_mark = cmd_pos;
						prof_phase = PH_REV_DEC;
						glide_rev();
					end else begin
						speed_up();
						cmd_pos = clamp_pos(cmd_pos - step_size(cur_vel));
					end
				end
				PH_REV_DEC: glide_rev();
				default: prof_phase = PH_IDLE;
			endcase
		end
		r.pos = cmd_pos[31:0];
		r.moving = (prof_phase != PH_IDLE);
		r.done = landed;
		r.ph = prof_phase;
		return r;
	endfunction

	// sender works in bursts with idle gaps between them
	task automatic drive_word(logic [1:0] op, logic signed [31:0] tgt, logic [15:0] vel,
			logic [15:0] acc);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		target <= tgt;
		peak_velocity <= vel;
		acceleration <= acc;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic issue(logic [1:0] op, logic signed [31:0] tgt, logic [15:0] vel,
			logic [15:0] acc);
		// ticks while idle change nothing and are not counted
		if (!((op == OP_TICK || op == OP_SPARE) && prof_phase == PH_IDLE))
			counted_words++;
		predicted_profile.push_back(step_profile(op, tgt, vel, acc));
		drive_word(op, tgt, vel, acc);
	endtask

	task automatic tick_word();
		issue(($urandom_range(0, 19) == 0) ? OP_SPARE : OP_TICK, $urandom, 16'($urandom),
			16'($urandom));
	endtask

	// well-formed move: a start, then ticks until it lands or is cut short
	task automatic random_move();
		logic [1:0]         op;
		logic [15:0]        vel;
		logic [15:0]        acc;
		logic signed [31:0] tgt;
		longint             span;
		int                 k;
		int                 cap;
		int                 n;
		k = $urandom_range(0, 19);
		vel = (k == 0) ? 16'd0 : (k < 3) ? 16'($urandom) : 16'($urandom_range(200, 20000));
		k = $urandom_range(0, 19);
		acc = (k == 0) ? 16'd0 : (k < 3) ? 16'($urandom)
			: 16'($urandom_range(1, vel / 4 + 1));
		span = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 60000))
			: longint'($urandom_range(0, vel / 10 * 25 + 20));
		if ($urandom_range(0, 1))
			span = -span;
		op = $urandom_range(0, 1) ? OP_ABS : OP_REL;
		tgt = (op == OP_REL) ? 32'(span) : 32'(clamp_pos(cmd_pos + span));
		issue(op, tgt, vel, acc);
		cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 150;
		n = 0;
		while (prof_phase != PH_IDLE && n < cap) begin
			tick_word();
			n++;
		end
	endtask

	task automatic random_noise();
		int n;
		if ($urandom_range(0, 1)) begin
			issue($urandom_range(0, 1) ? OP_ABS : OP_REL, $urandom, 16'($urandom),
				16'($urandom));
			n = $urandom_range(1, 20);
		end else
			n = $urandom_range(1, 4);
		repeat (n)
			tick_word();
	endtask

	initial begin
		stim_row_t dir_rows[N_DIR];
		profile_out_t want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		target = '0;
		peak_velocity = '0;
		acceleration = '0;
		cmd_pos = 0;
		brake_mark = 0;
		goal_pos = 0;
		cur_vel = 0;
		vel_cap = 0;
		accel_inc = 0;
		prof_phase = PH_IDLE;
		landed = 1'b0;
		burst_left = 0;
		counted_words = 0;
		dir_rows = '{
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b1, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_SPARE, 32'sh7fff_ffff, 16'hffff, 16'hffff, 1'b1, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			// goal equal to position runs as a reverse move
			'{OP_ABS, 32'sd0, 16'd100, 16'd50, 1'b1, 32'sd0, 1'b1, 1'b0, PH_REV_ACC},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			// zero peak velocity forward holds
			'{OP_ABS, 32'sd40, 16'd0, 16'd30, 1'b1, 32'sd0, 1'b1, 1'b0, PH_FWD_ACC},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b1, 32'sd0, 1'b1, 1'b0, PH_FWD_ACC},
			'{OP_TICK, -32'sd1, 16'hffff, 16'hffff, 1'b1, 32'sd0, 1'b1, 1'b0, PH_FWD_ACC},
			'{OP_REL, 32'sd1000, 16'hffff, 16'hffff, 1'b1, 32'sd0, 1'b1, 1'b0, PH_FWD_ACC},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_ABS, 32'sh8000_0000, 16'hffff, 16'hffff, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			// relative goal below the bottom saturates
			'{OP_REL, 32'sh8000_0000, 16'd500, 16'd3, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_SPARE, 32'sh5555_aaaa, 16'h5a5a, 16'ha5a5, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_REL, 32'sh7fff_ffff, 16'hffff, 16'hffff, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			// relative goal above the top saturates, zero acceleration
			'{OP_REL, 32'sh7fff_ffff, 16'd40000, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE},
			'{OP_TICK, 32'sd0, 16'd0, 16'd0, 1'b0, 32'sd0, 1'b0, 1'b0, PH_IDLE}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++) begin
			want = step_profile(dir_rows[i].op, dir_rows[i].tgt, dir_rows[i].vel,
				dir_rows[i].acc);
			if (dir_rows[i].typed) begin
				want.pos = dir_rows[i].want_pos;
				want.moving = dir_rows[i].want_moving;
				want.done = dir_rows[i].want_done;
				want.ph = dir_rows[i].want_ph;
			end
			predicted_profile.push_back(want);
			drive_word(dir_rows[i].op, dir_rows[i].tgt, dir_rows[i].vel, dir_rows[i].acc);
		end
		counted_words = 0;
		while (counted_words < N_RANDOM) begin
			if ($urandom_range(0, 4) == 0)
				random_noise();
			else
				random_move();
		end
		in_valid <= 1'b0;
		while (predicted_profile.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// result check and receiver stall pattern
	always @(posedge clk) begin
		profile_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_profile.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: pos %0d moving %0b done %0b phase %0d",
						command_position, moving, done_res, phase);
			end else begin
				want = predicted_profile.pop_front();
				if (want.pos !== command_position || want.moving !== moving
						|| want.done !== done_res || want.ph !== phase) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: want pos %0d moving %0b done %0b phase %0d,",
							" got pos %0d moving %0b done %0b phase %0d"},
							want.pos, want.moving, want.done, want.ph,
							command_position, moving, done_res, phase);
				end
			end
		end
		if (mode_age == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_age = $urandom_range(20, 120);
		end else
			mode_age--;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_mode == 1)
			out_stall <= ($urandom_range(0, 2) == 0);
		else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 15);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

endmodule
